>>> rtl/core/gcma_pkg.sv
package gcma_pkg;

    // Fixed field widths of the sample and result channels.
    localparam int COORD_W  = 5;
    localparam int SAMPLE_W = 16;

    // Default grid geometry and averaging window.
    localparam int DEF_GRID_COLUMNS = 32;
    localparam int DEF_GRID_ROWS    = 32;
    localparam int DEF_WINDOW       = 50;

endpackage

>>> rtl/core/grid_cell_moving_average.sv
// Channel   Direction  Handshake           Payload
// sample    in         i_valid / o_ready   i_cell_column, i_cell_row, i_sample
// result    out        o_valid / i_ready   o_out_column, o_out_row, o_mean_intensity
//
// One sample is processed at a time. An in-grid sample passes through the states CELL,
// SREAD, SDATA, HDATA and DIV before DONE loads its result; the bit-serial divider
// forms sum / fill one quotient bit per cycle. An off-grid sample goes straight to DONE.
// After reset the per-cell state memory is cleared while o_ready stays low.
// A new sample is taken while a finished result still waits in the output register;
// the next result waits for that register to empty.
module grid_cell_moving_average #(
    parameter int GRID_COLUMNS = gcma_pkg::DEF_GRID_COLUMNS,
    parameter int GRID_ROWS    = gcma_pkg::DEF_GRID_ROWS,
    parameter int WINDOW       = gcma_pkg::DEF_WINDOW
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [gcma_pkg::COORD_W-1:0]     i_cell_column,
    input  logic [gcma_pkg::COORD_W-1:0]     i_cell_row,
    input  logic [gcma_pkg::SAMPLE_W-1:0]    i_sample,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [gcma_pkg::COORD_W-1:0]     o_out_column,
    output logic [gcma_pkg::COORD_W-1:0]     o_out_row,
    output logic [gcma_pkg::SAMPLE_W-1:0]    o_mean_intensity
);

    import gcma_pkg::*;

    localparam int CELL_COUNT = GRID_COLUMNS * GRID_ROWS;
    localparam int CELL_W     = CELL_COUNT > 1 ? $clog2(CELL_COUNT) : 1;
    localparam int HIST_DEPTH = CELL_COUNT * WINDOW;
    localparam int HIST_W     = HIST_DEPTH > 1 ? $clog2(HIST_DEPTH) : 1;
    localparam int SLOT_W     = WINDOW > 1 ? $clog2(WINDOW) : 1;
    localparam int FILL_W     = $clog2(WINDOW + 1);
    localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW);
    localparam int STATE_W    = SUM_W + FILL_W + SLOT_W;
    localparam int DIVC_W     = $clog2(SUM_W);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CELL  = 3'd2;
    localparam logic [2:0] S_SREAD = 3'd3;
    localparam logic [2:0] S_SDATA = 3'd4;
    localparam logic [2:0] S_HDATA = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]            r_state, n_state;
    logic [CELL_W-1:0]     r_clr_idx, n_clr_idx;
    logic [COORD_W-1:0]    r_col, n_col;
    logic [COORD_W-1:0]    r_row, n_row;
    logic [SAMPLE_W-1:0]   r_sample, n_sample;
    logic [CELL_W-1:0]     r_cell, n_cell;
    logic [HIST_W-1:0]     r_hist_base, n_hist_base;
    logic [HIST_W-1:0]     r_hist_addr, n_hist_addr;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic [FILL_W-1:0]     r_fill, n_fill;
    logic [SUM_W-1:0]      r_sum, n_sum;
    logic [SUM_W-1:0]      r_dividend, n_dividend;
    logic [FILL_W-1:0]     r_div, n_div;
    logic [FILL_W-1:0]     r_rem, n_rem;
    logic [SUM_W-1:0]      r_quot, n_quot;
    logic [DIVC_W-1:0]     r_bit, n_bit;
    logic                  r_out_valid, n_out_valid;
    logic [COORD_W-1:0]    r_out_col, n_out_col;
    logic [COORD_W-1:0]    r_out_row, n_out_row;
    logic [SAMPLE_W-1:0]   r_out_mean, n_out_mean;

    logic                  state_we;
    logic [CELL_W-1:0]     state_waddr;
    logic [STATE_W-1:0]    state_wdata;
    logic [STATE_W-1:0]    state_rdata;
    logic                  hist_we;
    logic [HIST_W-1:0]     hist_raddr;
    logic [SAMPLE_W-1:0]   hist_rdata;

    logic [SUM_W-1:0]      rd_sum;
    logic [FILL_W-1:0]     rd_fill;
    logic [SLOT_W-1:0]     rd_slot;
    logic [SLOT_W-1:0]     slot_use;
    logic                  in_grid;
    logic                  window_full;
    logic [SUM_W-1:0]      upd_sum;
    logic [FILL_W-1:0]     upd_fill;
    logic [SLOT_W-1:0]     upd_slot;
    logic [FILL_W:0]       rem_shift;
    logic                  quot_bit;
    logic                  out_free;

    gcma_ram #(
        .WIDTH (STATE_W),
        .DEPTH (CELL_COUNT)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (state_we),
        .i_waddr (state_waddr),
        .i_wdata (state_wdata),
        .i_raddr (r_cell),
        .o_rdata (state_rdata)
    );

    gcma_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (r_hist_addr),
        .i_wdata (r_sample),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    assign {rd_sum, rd_fill, rd_slot} = state_rdata;

    // A slot index past the window end wraps to the first slot.
    assign slot_use   = (int'(rd_slot) >= WINDOW) ? '0 : rd_slot;
    assign hist_raddr = r_hist_base + HIST_W'(slot_use);

    assign in_grid     = (int'(i_cell_column) < GRID_COLUMNS) && (int'(i_cell_row) < GRID_ROWS);
    assign window_full = int'(r_fill) >= WINDOW;

    // Once the window is full the oldest sample sits in the slot about to be overwritten.
    assign upd_sum  = window_full ? (r_sum - SUM_W'(hist_rdata) + SUM_W'(r_sample))
                                  : (r_sum + SUM_W'(r_sample));
    assign upd_fill = window_full ? FILL_W'(WINDOW) : (r_fill + 1'b1);
    assign upd_slot = (int'(r_slot) == WINDOW - 1) ? '0 : (r_slot + 1'b1);

    assign rem_shift = {r_rem, r_dividend[SUM_W-1]};
    assign quot_bit  = rem_shift >= {1'b0, r_div};

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        state_we    = 1'b0;
        state_waddr = r_cell;
        state_wdata = {upd_sum, upd_fill, upd_slot};
        hist_we     = 1'b0;
        case (r_state)
            S_CLEAR: begin
                state_we    = 1'b1;
                state_waddr = r_clr_idx;
                state_wdata = '0;
            end
            S_HDATA: begin
                state_we = 1'b1;
                hist_we  = 1'b1;
            end
            default: begin
                state_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_col       = r_col;
        n_row       = r_row;
        n_sample    = r_sample;
        n_cell      = r_cell;
        n_hist_base = r_hist_base;
        n_hist_addr = r_hist_addr;
        n_slot      = r_slot;
        n_fill      = r_fill;
        n_sum       = r_sum;
        n_dividend  = r_dividend;
        n_div       = r_div;
        n_rem       = r_rem;
        n_quot      = r_quot;
        n_bit       = r_bit;
        n_out_valid = r_out_valid && !i_ready;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        n_out_mean  = r_out_mean;
        case (r_state)
            S_CLEAR: begin
                n_clr_idx = r_clr_idx + 1'b1;
                if (int'(r_clr_idx) == CELL_COUNT - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_col    = i_cell_column;
                    n_row    = i_cell_row;
                    n_sample = i_sample;
                    if (in_grid) begin
                        n_state = S_CELL;
                    end else begin
                        n_quot  = '0;
                        n_state = S_DONE;
                    end
                end
            end
            S_CELL: begin
                n_cell  = CELL_W'(r_row) * CELL_W'(GRID_COLUMNS) + CELL_W'(r_col);
                n_state = S_SREAD;
            end
            S_SREAD: begin
                n_hist_base = HIST_W'(r_cell) * HIST_W'(WINDOW);
                n_state     = S_SDATA;
            end
            S_SDATA: begin
                n_slot      = slot_use;
                n_fill      = rd_fill;
                n_sum       = rd_sum;
                n_hist_addr = hist_raddr;
                n_state     = S_HDATA;
            end
            S_HDATA: begin
                n_dividend = upd_sum;
                n_div      = upd_fill;
                n_rem      = '0;
                n_quot     = '0;
                n_bit      = DIVC_W'(SUM_W - 1);
                n_state    = S_DIV;
            end
            S_DIV: begin
                n_rem      = quot_bit ? FILL_W'(rem_shift - {1'b0, r_div})
                                      : FILL_W'(rem_shift);
                n_quot     = {r_quot[SUM_W-2:0], quot_bit};
                n_dividend = {r_dividend[SUM_W-2:0], 1'b0};
                n_bit      = r_bit - 1'b1;
                if (r_bit == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_col   = r_col;
                    n_out_row   = r_row;
                    n_out_mean  = r_quot[SAMPLE_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col       <= n_col;
        r_row       <= n_row;
        r_sample    <= n_sample;
        r_cell      <= n_cell;
        r_hist_base <= n_hist_base;
        r_hist_addr <= n_hist_addr;
        r_slot      <= n_slot;
        r_fill      <= n_fill;
        r_sum       <= n_sum;
        r_dividend  <= n_dividend;
        r_div       <= n_div;
        r_rem       <= n_rem;
        r_quot      <= n_quot;
        r_bit       <= n_bit;
        r_out_col   <= n_out_col;
        r_out_row   <= n_out_row;
        r_out_mean  <= n_out_mean;
    end

    assign o_ready          = r_state == S_IDLE;
    assign o_valid          = r_out_valid;
    assign o_out_column     = r_out_col;
    assign o_out_row        = r_out_row;
    assign o_mean_intensity = r_out_mean;

    // The divider never runs with a zero fill count.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div != '0))
        else $error("divider started with zero divisor");

    // A stored fill count never exceeds the window.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HDATA) |-> (int'(upd_fill) <= WINDOW))
        else $error("fill count exceeds window");

    // History writes stay inside the memory.
    a_hist_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hist_we |-> (int'(r_hist_addr) < HIST_DEPTH))
        else $error("history address out of range");

    // A finished result is loaded into the output register.
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not loaded");

    // No sample is taken during the clearing pass.
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_ready)
        else $error("ready during clearing pass");

endmodule

>>> rtl/core/gcma_ram.sv
module gcma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> test/grid_cell_moving_average_test.sv
`timescale 1ns / 1ps

module grid_cell_moving_average_test;
    import gcma_pkg::*;

    localparam int GRID_COLUMNS = DEF_GRID_COLUMNS;
    localparam int GRID_ROWS    = DEF_GRID_ROWS;
    localparam int WINDOW       = DEF_WINDOW;
    localparam int CELL_COUNT   = GRID_COLUMNS * GRID_ROWS;
    localparam int SUM_BITS     = 22;
    localparam int MAX_GAP      = 9;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [COORD_W-1:0]  column;
        logic [COORD_W-1:0]  row;
        logic [SAMPLE_W-1:0] mean;
    } cell_mean_t;

    typedef enum int {
        STYLE_RANDOM,
        STYLE_FULL_SCALE,
        STYLE_LOW
    } sample_style_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [COORD_W-1:0]  i_cell_column;
    logic [COORD_W-1:0]  i_cell_row;
    logic [SAMPLE_W-1:0] i_sample;
    logic                o_valid;
    logic                i_ready;
    logic [COORD_W-1:0]  o_out_column;
    logic [COORD_W-1:0]  o_out_row;
    logic [SAMPLE_W-1:0] o_mean_intensity;

    grid_cell_moving_average #(
        .GRID_COLUMNS(GRID_COLUMNS),
        .GRID_ROWS   (GRID_ROWS),
        .WINDOW      (WINDOW)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cell_column   (i_cell_column),
        .i_cell_row      (i_cell_row),
        .i_sample        (i_sample),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_column    (o_out_column),
        .o_out_row       (o_out_row),
        .o_mean_intensity(o_mean_intensity)
    );

    // Shadow copy of the per-cell window state.
    logic [SAMPLE_W-1:0] shadow_history [CELL_COUNT][WINDOW];
    logic [SUM_BITS-1:0] shadow_sum [CELL_COUNT];
    int unsigned         shadow_fill [CELL_COUNT];
    int unsigned         shadow_slot [CELL_COUNT];

    cell_mean_t  pending_means[$];
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned ready_hold;
    bit          idle_on;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_means.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Pushes one sample through the shadow window and returns the new mean (zero off-grid).
    function automatic logic [SAMPLE_W-1:0] update_cell_mean(
        input logic [COORD_W-1:0]  column,
        input logic [COORD_W-1:0]  row,
        input logic [SAMPLE_W-1:0] sample
    );
        int unsigned         cell_idx;
        int unsigned         slot;
        logic [SUM_BITS-1:0] acc;
        if (int'(column) >= GRID_COLUMNS || int'(row) >= GRID_ROWS)
            return '0;
        cell_idx = int'(row) * GRID_COLUMNS + int'(column);
        slot = shadow_slot[cell_idx];
        acc = shadow_sum[cell_idx];
        if (shadow_fill[cell_idx] >= WINDOW)
            acc = acc - shadow_history[cell_idx][slot];
        else
            shadow_fill[cell_idx]++;
        shadow_history[cell_idx][slot] = sample;
        acc = acc + SUM_BITS'(sample);
        shadow_sum[cell_idx] = acc;
        shadow_slot[cell_idx] = (slot + 1 >= WINDOW) ? 0 : slot + 1;
        return SAMPLE_W'(acc / shadow_fill[cell_idx]);
    endfunction

    function automatic logic [SAMPLE_W-1:0] draw_sample(input sample_style_t style);
        case (style)
            STYLE_FULL_SCALE: return SAMPLE_W'($urandom_range(16'hFFFF, 16'hFF00));
            STYLE_LOW:        return SAMPLE_W'($urandom_range(0, 16'h00FF));
            default:          return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    // Result side: checks each transfer and, while idling is on, stalls ready for a random gap.
    always @(posedge i_clk) begin
        cell_mean_t got;
        cell_mean_t want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            got = '{column: o_out_column, row: o_out_row, mean: o_mean_intensity};
            if (pending_means.size() == 0) begin
                note_mismatch($sformatf("unexpected result col %0d row %0d mean %h",
                                        got.column, got.row, got.mean));
            end else begin
                want = pending_means[0];
                pending_means.delete(0);
                if (got.column !== want.column || got.row !== want.row
                        || got.mean !== want.mean)
                    note_mismatch($sformatf(
                        "expected col %0d row %0d mean %h, got col %0d row %0d mean %h",
                        want.column, want.row, want.mean, got.column, got.row, got.mean));
            end
            ready_hold = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        end
        if (ready_hold != 0) begin
            ready_hold--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Called at a rising edge; returns at the edge where the sample transfers.
    // Valid is only lowered when a gap follows, so it never drops and rises in one step.
    task automatic send_sample(
        input logic [COORD_W-1:0]  column,
        input logic [COORD_W-1:0]  row,
        input logic [SAMPLE_W-1:0] sample
    );
        int unsigned gap;
        cell_mean_t  expected_item;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_cell_column <= column;
        i_cell_row    <= row;
        i_sample      <= sample;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        expected_item = '{column: column, row: row,
                          mean: update_cell_mean(column, row, sample)};
        pending_means.insert(pending_means.size(), expected_item);
    endtask

    // Holds the sample side off until every expected result has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_means.size() != 0);
    endtask

    task automatic test_corner_cells();
        send_sample(5'd0, 5'd0, 16'h0000);
        send_sample(5'd31, 5'd31, 16'hFFFF);
        send_sample(5'd31, 5'd0, 16'h8000);
        send_sample(5'd0, 5'd31, 16'h0001);
        send_sample(5'd0, 5'd0, 16'hFFFF);
        send_sample(5'd31, 5'd31, 16'hFFFF);
        send_sample(5'd21, 5'd10, 16'h5555);
        send_sample(5'd10, 5'd21, 16'hAAAA);
    endtask

    // Means that do not divide evenly must truncate.
    task automatic test_truncation();
        send_sample(5'd3, 5'd5, 16'h0001);
        send_sample(5'd3, 5'd5, 16'h0002);
        send_sample(5'd3, 5'd5, 16'hFFFF);
        send_sample(5'd3, 5'd5, 16'h0000);
        send_sample(5'd7, 5'd9, 16'hFFFE);
        send_sample(5'd7, 5'd9, 16'h0001);
        send_sample(5'd7, 5'd9, 16'h0001);
    endtask

    // Long runs on a few cells so the window fills, wraps and evicts.
    task automatic test_window_wrap(input int unsigned item_budget);
        logic [COORD_W-1:0] hot_column [4];
        logic [COORD_W-1:0] hot_row [4];
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        sample_style_t      style;
        int unsigned        run_length;
        int unsigned        pick;
        int unsigned        sent;
        hot_column[0] = 5'd31;
        hot_row[0]    = 5'd31;
        for (int k = 1; k < 4; k++) begin
            hot_column[k] = COORD_W'($urandom);
            hot_row[k]    = COORD_W'($urandom);
        end
        sent = 0;
        while (sent < item_budget) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) != 0) begin
                pick   = $urandom_range(0, 3);
                column = hot_column[pick];
                row    = hot_row[pick];
            end else begin
                column = COORD_W'($urandom);
                row    = COORD_W'($urandom);
            end
            style = sample_style_t'($urandom_range(0, 2));
            run_length = $urandom_range(1, 2 * WINDOW + 20);
            for (int n = 0; n < run_length && sent < item_budget; n++) begin
                send_sample(column, row, draw_sample(style));
                sent++;
            end
        end
        idle_on = 1'b1;
    endtask

    task automatic test_scattered_cells(input int unsigned item_count);
        for (int n = 0; n < item_count; n++)
            send_sample(COORD_W'($urandom), COORD_W'($urandom), SAMPLE_W'($urandom));
    endtask

    // No idling on either side; two cells interleaved so same-cell updates follow closely.
    task automatic test_back_to_back(input int unsigned item_count);
        idle_on = 1'b0;
        for (int n = 0; n < item_count; n++) begin
            if ($urandom_range(0, 1) != 0)
                send_sample(5'd12, 5'd4, draw_sample(STYLE_RANDOM));
            else
                send_sample(5'd13, 5'd4, draw_sample(STYLE_FULL_SCALE));
        end
        idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ready        = 1'b0;
        i_cell_column  = '0;
        i_cell_row     = '0;
        i_sample       = '0;
        idle_on        = 1'b1;
        ready_hold     = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        for (int k = 0; k < CELL_COUNT; k++) begin
            shadow_sum[k]  = '0;
            shadow_fill[k] = 0;
            shadow_slot[k] = 0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_cells();
        test_truncation();
        wait_drained();
        test_window_wrap(700);
        wait_drained();
        test_scattered_cells(230);
        test_back_to_back(160);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_means.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", pending_means.size()));
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
